// File: hdl/tdr_pkg.sv
`default_nettype none

package tdr_pkg;

	localparam int unsigned HEADER_BYTES = 4;
	localparam int unsigned CFG_INDEX_W  = 1;

	localparam logic [15:0] DATA_OPCODE       = 16'd3;
	localparam logic [15:0] BLOCK_SIZE_RESET  = 16'd512;
	localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd5;
	localparam logic [7:0]  TIMEOUT_MAX       = 8'd255;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RETRY_LIMIT = 1'd1;

	typedef enum logic [1:0] {
		EV_START      = 2'd0,
		EV_PACKET     = 2'd1,
		EV_TIMEOUT    = 2'd2,
		EV_LINK_ERROR = 2'd3
	} tdr_event_t;

	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_ACK    = 3'd1,
		ACT_FINAL  = 3'd2,
		ACT_ERROR  = 3'd3,
		ACT_SILENT = 3'd4
	} tdr_action_t;

	localparam logic [2:0] ERR_CODE_NONE    = 3'd0;
	localparam logic [2:0] ERR_CODE_DISK    = 3'd1;
	localparam logic [2:0] ERR_CODE_ILLEGAL = 3'd4;

	localparam logic [2:0] REASON_NONE     = 3'd0;
	localparam logic [2:0] REASON_OVERSIZE = 3'd1;
	localparam logic [2:0] REASON_OPCODE   = 3'd2;
	localparam logic [2:0] REASON_AHEAD    = 3'd3;
	localparam logic [2:0] REASON_TIMEOUT  = 3'd4;

	typedef struct packed {
		logic [15:0] block_size;
		logic [7:0]  retry_limit;
	} tdr_cfg_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] packet_length;
		logic [15:0] packet_opcode;
		logic [15:0] block_number;
	} tdr_item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] ack_block;
		logic [2:0]  err_code;
		logic [2:0]  error_reason;
		logic        payload_accept;
		logic [15:0] payload_length;
	} tdr_result_t;

endpackage

`default_nettype wire

// File: hdl/tdr_cfg_regs.sv
`default_nettype none

module tdr_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	input  wire logic [tdr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [15:0]                        cfg_data,
	output tdr_pkg::tdr_cfg_t                       cfg
);

	logic [15:0] block_size_q;
	logic [7:0]  retry_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q  <= tdr_pkg::BLOCK_SIZE_RESET;
			retry_limit_q <= tdr_pkg::RETRY_LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				tdr_pkg::REG_BLOCK_SIZE:  block_size_q  <= cfg_data;
				tdr_pkg::REG_RETRY_LIMIT: retry_limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg.block_size  = block_size_q;
	assign cfg.retry_limit = retry_limit_q;

endmodule

`default_nettype wire

// File: hdl/tdr_in_reg.sv
`default_nettype none

module tdr_in_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire tdr_pkg::tdr_item_t item_in,
	input  wire logic               advance,
	output logic                    valid_s1,
	output tdr_pkg::tdr_item_t      item_s1
);

	// hold the item while the next stage cannot take it
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item_in;
		end
	end

endmodule

`default_nettype wire

// File: hdl/tdr_proto.sv
`default_nettype none

module tdr_proto (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire tdr_pkg::tdr_item_t item,
	input  wire tdr_pkg::tdr_cfg_t  cfg,
	output tdr_pkg::tdr_result_t    result
);

	logic [15:0] last_block_q;
	logic [7:0]  timeout_count_q;
	logic        finished_q;

	logic [15:0] last_block_d;
	logic [7:0]  timeout_count_d;
	logic        finished_d;

	logic [16:0] full_len;
	logic [16:0] plen_ext;
	logic [16:0] next_block;
	logic [15:0] pay_len;
	logic [7:0]  tc_inc;

	assign full_len   = {1'b0, cfg.block_size} + 17'(tdr_pkg::HEADER_BYTES);
	assign plen_ext   = {1'b0, item.packet_length};
	assign next_block = {1'b0, last_block_q} + 17'd1;
	assign pay_len    = (item.packet_length >= 16'(tdr_pkg::HEADER_BYTES)) ?
		item.packet_length - 16'(tdr_pkg::HEADER_BYTES) : 16'd0;
	assign tc_inc     = (timeout_count_q == tdr_pkg::TIMEOUT_MAX) ?
		timeout_count_q : timeout_count_q + 8'd1;

	always_comb begin
		result          = '0;
		last_block_d    = last_block_q;
		timeout_count_d = timeout_count_q;
		finished_d      = finished_q;
		if (!finished_q) begin
			case (tdr_pkg::tdr_event_t'(item.opcode))
				tdr_pkg::EV_START: begin
					result.action    = tdr_pkg::ACT_ACK;
					result.ack_block = last_block_q;
				end
				tdr_pkg::EV_PACKET: begin
					if (plen_ext > full_len) begin
						result.action       = tdr_pkg::ACT_ERROR;
						result.err_code     = tdr_pkg::ERR_CODE_DISK;
						result.error_reason = tdr_pkg::REASON_OVERSIZE;
						finished_d          = 1'b1;
					end else if (item.packet_opcode != tdr_pkg::DATA_OPCODE) begin
						result.action       = tdr_pkg::ACT_ERROR;
						result.err_code     = tdr_pkg::ERR_CODE_ILLEGAL;
						result.error_reason = tdr_pkg::REASON_OPCODE;
						finished_d          = 1'b1;
					end else if (item.block_number <= last_block_q) begin
						// duplicate or old block: acknowledge again
						result.action    = tdr_pkg::ACT_ACK;
						result.ack_block = last_block_q;
					end else if ({1'b0, item.block_number} == next_block) begin
						last_block_d          = next_block[15:0];
						timeout_count_d       = '0;
						result.ack_block      = next_block[15:0];
						result.payload_accept = 1'b1;
						result.payload_length = pay_len;
						if (plen_ext == full_len) begin
							result.action = tdr_pkg::ACT_ACK;
						end else begin
							result.action = tdr_pkg::ACT_FINAL;
							finished_d    = 1'b1;
						end
					end else begin
						result.action       = tdr_pkg::ACT_ERROR;
						result.err_code     = tdr_pkg::ERR_CODE_ILLEGAL;
						result.error_reason = tdr_pkg::REASON_AHEAD;
						finished_d          = 1'b1;
					end
				end
				tdr_pkg::EV_TIMEOUT: begin
					timeout_count_d = tc_inc;
					if (tc_inc > cfg.retry_limit) begin
						result.action       = tdr_pkg::ACT_ERROR;
						result.err_code     = tdr_pkg::ERR_CODE_ILLEGAL;
						result.error_reason = tdr_pkg::REASON_TIMEOUT;
						finished_d          = 1'b1;
					end else begin
						result.action    = tdr_pkg::ACT_ACK;
						result.ack_block = last_block_q;
					end
				end
				default: begin
					result.action = tdr_pkg::ACT_SILENT;
					finished_d    = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_block_q    <= '0;
			timeout_count_q <= '0;
			finished_q      <= 1'b0;
		end else if (fire) begin
			last_block_q    <= last_block_d;
			timeout_count_q <= timeout_count_d;
			finished_q      <= finished_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/tdr_out_reg.sv
`default_nettype none

module tdr_out_reg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 valid_s1,
	input  wire tdr_pkg::tdr_result_t result_in,
	output logic                      advance,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output tdr_pkg::tdr_result_t      result_q
);

	// the register is free when empty or when its item leaves this cycle
	assign advance = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result_in;
		end
	end

endmodule

`default_nettype wire

// File: hdl/tftp_data_receiver_core.sv
// TFTP write-transfer receiver: decides the reply for each transfer event.
//
// Item input: item_valid / item_stall with opcode (start, packet, timeout,
// link error) and the received packet header fields. Result output:
// result_valid / result_stall carrying the action (none, ACK, final ACK,
// ERROR, silent end), ACK block, error code and reason, and whether the
// packet payload is new (with its length).
// Configuration: cfg_valid / cfg_ready write block_size (index 0) and
// retry_limit (index 1); cfg_ready is always high. Write only while idle.
//
// Path: an accepted item enters the input register, then passes through the
// decision logic into the result register, where result_valid rises.
// Throughput: one item per cycle while result_stall is low; the only
// loop is the update of the transfer state (last block, timeout count,
// finished) as an item enters the result register.
// Reset: state clears (transfer active, last block 0), both stages empty,
// registers return to 512 and 5. No clearing pass is needed.
// Stall: a stalled result holds; one more item waits in the input register,
// then item_stall rises. Once finished, every event yields action none.
`default_nettype none

module tftp_data_receiver_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// item channel
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic [1:0]                       opcode,
	input  wire logic [15:0]                      packet_length,
	input  wire logic [15:0]                      packet_opcode,
	input  wire logic [15:0]                      block_number,
	// result channel
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output logic [2:0]                            action,
	output logic [15:0]                           ack_block,
	output logic [2:0]                            err_code,
	output logic [2:0]                            error_reason,
	output logic                                  payload_accept,
	output logic [15:0]                           payload_length,
	// configuration write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [tdr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [15:0]                      cfg_data
);

	tdr_pkg::tdr_cfg_t    cfg;
	tdr_pkg::tdr_item_t   item_in;
	tdr_pkg::tdr_item_t   item_s1;
	tdr_pkg::tdr_result_t result_d;
	tdr_pkg::tdr_result_t result_q;
	logic                 valid_s1;
	logic                 advance;
	logic                 fire;

	// registers accept every write
	assign cfg_ready = 1'b1;

	tdr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign item_in.opcode        = opcode;
	assign item_in.packet_length = packet_length;
	assign item_in.packet_opcode = packet_opcode;
	assign item_in.block_number  = block_number;

	// stage 1: capture the event
	tdr_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_in    (item_in),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// commit state exactly when the stage-1 item moves into the result register
	assign fire = valid_s1 && advance;

	tdr_proto u_proto (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_d)
	);

	// stage 2: hold the result until taken
	tdr_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.result_in    (result_d),
		.advance      (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_q     (result_q)
	);

	assign action         = result_q.action;
	assign ack_block      = result_q.ack_block;
	assign err_code       = result_q.err_code;
	assign error_reason   = result_q.error_reason;
	assign payload_accept = result_q.payload_accept;
	assign payload_length = result_q.payload_length;

endmodule

`default_nettype wire

// File: hdl/tdr_checker.sv
`default_nettype none

module tdr_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        result_valid,
	input  wire logic        result_stall,
	input  wire logic [2:0]  action,
	input  wire logic [15:0] ack_block,
	input  wire logic [2:0]  err_code,
	input  wire logic        payload_accept,
	input  wire logic [15:0] payload_length
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(action)
			&& $stable(ack_block))
	else $error("stalled result changed");

	// an error code appears with an ERROR action and only then
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((action == tdr_pkg::ACT_ERROR) == (err_code != 3'd0)))
	else $error("error code does not match action");

	// new payload only with an ACK or final ACK
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && payload_accept |->
			(action == tdr_pkg::ACT_ACK || action == tdr_pkg::ACT_FINAL))
	else $error("payload accepted without ACK");

	// ACK block and payload length are zero outside ACK actions
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && action != tdr_pkg::ACT_ACK && action != tdr_pkg::ACT_FINAL
			|-> ack_block == 16'd0 && payload_length == 16'd0)
	else $error("fields set without ACK");

endmodule

bind tftp_data_receiver_core tdr_checker u_tdr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.action         (action),
	.ack_block      (ack_block),
	.err_code       (err_code),
	.payload_accept (payload_accept),
	.payload_length (payload_length)
);

`default_nettype wire
